/* rtl/core/aop_pkg.sv */
package aop_pkg;

	// defaults for the top-level parameters
	localparam int CHANNELS_DEF    = 2;
	localparam int SAMPLE_BITS_DEF = 24;

	// field widths
	localparam int POLE_W = 16;
	localparam int THR_W  = 27;
	localparam int CNT_W  = 20;
	localparam int GAIN_W = 25;
	localparam int LVL_W  = 23;
	localparam int OUT_W  = 28;
	localparam int FB_W   = OUT_W + 1;
	localparam int ACC_W  = OUT_W + GAIN_W;
	localparam int STEP_W = $clog2(GAIN_W);

	localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << (GAIN_W - 1));

	// register map, index = paddr[4:2]
	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_DC_POLE   = 3'd0;
	localparam logic [2:0] REG_THRESHOLD = 3'd1;
	localparam logic [2:0] REG_MUTE      = 3'd2;
	localparam logic [2:0] REG_RECOVERY  = 3'd3;
	localparam logic [2:0] REG_STEP      = 3'd4;
	localparam logic [2:0] REG_CEIL_EN   = 3'd5;
	localparam logic [2:0] REG_CEIL_LVL  = 3'd6;

	// trigger cause codes
	localparam logic [1:0] CAUSE_NONE    = 2'd0;
	localparam logic [1:0] CAUSE_INVALID = 2'd1;
	localparam logic [1:0] CAUSE_PEAK    = 2'd2;

	// sequencer to lane controls
	typedef struct packed {
		logic load_x;      // capture sample, load pole bits, clear acc
		logic step;        // one shift-add step
		logic gain_phase;  // multiplicand is filtered sample, else last output
		logic filt_done;   // close the filter, update lane history
		logic load_gain;   // load gain bits, clear acc
	} aop_ctrl_t;

endpackage

/* rtl/core/aop_lane.sv */
module aop_lane #(
	parameter int SAMPLE_BITS = aop_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  aop_pkg::aop_ctrl_t                    ctrl,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  invalid,
	input  logic [aop_pkg::POLE_W-1:0]            pole,
	input  logic [aop_pkg::GAIN_W-1:0]            gain,
	input  logic                                  ceil_en,
	input  logic [aop_pkg::LVL_W-1:0]             ceil_lvl,
	output logic signed [aop_pkg::OUT_W-1:0]      filtered,
	output logic signed [aop_pkg::OUT_W-1:0]      result
);
	import aop_pkg::*;

	localparam int SUM_W = ((SAMPLE_BITS > OUT_W) ? SAMPLE_BITS : OUT_W) + 2;
	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;
	localparam logic signed [FB_W-1:0]  V_HI   = FB_W'((1 << (OUT_W - 1)) - 1);
	localparam logic signed [FB_W-1:0]  V_LO   = ~V_HI;

	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [SAMPLE_BITS-1:0] x1_q;
	logic signed [OUT_W-1:0]       lf_q;
	logic signed [OUT_W-1:0]       y_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic [GAIN_W-1:0]             mbits_q;

	logic signed [OUT_W-1:0]  mcand;
	logic signed [ACC_W-1:0]  addend;
	logic signed [ACC_W-1:0]  fb_rnd;
	logic signed [ACC_W-1:0]  g_rnd;
	logic signed [FB_W-1:0]   fb;
	logic signed [SUM_W-1:0]  sum;
	logic signed [OUT_W-1:0]  y_sat;
	logic signed [FB_W-1:0]   v;
	logic signed [FB_W-1:0]   lim;
	logic signed [FB_W-1:0]   v_clamp;

	// MSB-first shift-add, one multiplier bit per cycle
	assign mcand  = ctrl.gain_phase ? y_q : lf_q;
	assign addend = mbits_q[GAIN_W-1] ? ACC_W'(mcand) : '0;

	assign fb_rnd = acc_q + ACC_W'(1 << (POLE_W - 1));
	assign fb     = fb_rnd[POLE_W +: FB_W];
	assign sum    = SUM_W'(x_s1) - SUM_W'(x1_q) + SUM_W'(fb);

	always_comb begin
		if (sum > SUM_HI) begin
			y_sat = SUM_HI[OUT_W-1:0];
		end else if (sum < SUM_LO) begin
			y_sat = SUM_LO[OUT_W-1:0];
		end else begin
			y_sat = sum[OUT_W-1:0];
		end
	end

	assign g_rnd = acc_q + ACC_W'(1 << (GAIN_W - 2));
	assign v     = g_rnd[GAIN_W-1 +: FB_W];
	assign lim   = FB_W'(ceil_lvl);

	always_comb begin
		v_clamp = v;
		if (ceil_en) begin
			if (v > lim) begin
				v_clamp = lim;
			end else if (v < -lim) begin
				v_clamp = -lim;
			end
		end
		if (v_clamp > V_HI) begin
			result = V_HI[OUT_W-1:0];
		end else if (v_clamp < V_LO) begin
			result = V_LO[OUT_W-1:0];
		end else begin
			result = v_clamp[OUT_W-1:0];
		end
	end

	assign filtered = y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			lf_q <= '0;
		end else if (ctrl.filt_done) begin
			x1_q <= x_s1;
			lf_q <= y_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_x) begin
			x_s1 <= invalid ? '0 : sample;
		end
		if (ctrl.filt_done) begin
			y_q <= y_sat;
		end
		if (ctrl.load_x) begin
			acc_q   <= '0;
			mbits_q <= {pole, (GAIN_W - POLE_W)'(0)};
		end else if (ctrl.load_gain) begin
			acc_q   <= '0;
			mbits_q <= gain;
		end else if (ctrl.step) begin
			acc_q   <= (acc_q <<< 1) + addend;
			mbits_q <= mbits_q << 1;
		end
	end

endmodule

/* rtl/core/audio_output_protector.sv */
// The sequencer runs each frame through the states filter, evaluate, gain and
// done; the bit-serial multipliers step through the pole bits for the filter
// feedback and the gain bits for the gain. A new input frame is taken only
// after the last one has left the done state, which waits while m_axis stalls.
// Reset (arst_n low, asynchronous) restores register defaults, clears the
// filter history, returns to normal mode at unity gain and empties the output.
module audio_output_protector #(
	parameter int CHANNELS    = aop_pkg::CHANNELS_DEF,
	parameter int SAMPLE_BITS = aop_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// config port
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [aop_pkg::ADDR_W-1:0]        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input frames
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// sample_left, sample_right, zero pad to bytes
	input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// invalid_left, invalid_right
	input  logic [1:0]                        s_axis_tuser,
	// output frames
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// out_left, out_right
	output logic [2*aop_pkg::OUT_W-1:0]       m_axis_tdata,
	// protection_active, trigger_cause[1:0]
	output logic [2:0]                        m_axis_tuser
);
	import aop_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_FILT = 5'b00010,
		ST_EVAL = 5'b00100,
		ST_GAIN = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_MUTED  = 3'b010,
		MODE_REC    = 3'b100
	} mode_t;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [POLE_W-1:0] pole_q;
	logic [THR_W-1:0]  thr_q;
	logic [CNT_W-1:0]  mute_cfg_q;
	logic [CNT_W-1:0]  rec_cfg_q;
	logic [GAIN_W-1:0] step_q;
	logic              ceil_en_q;
	logic [LVL_W-1:0]  ceil_lvl_q;

	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_q     <= POLE_W'(65493);
			thr_q      <= THR_W'(8388608);
			mute_cfg_q <= CNT_W'(48);
			rec_cfg_q  <= CNT_W'(48);
			step_q     <= GAIN_W'(349525);
			ceil_en_q  <= 1'b0;
			ceil_lvl_q <= LVL_W'(8378953);
		end else if (wr_en) begin
			case (reg_idx)
				REG_DC_POLE:   pole_q     <= pwdata[POLE_W-1:0];
				REG_THRESHOLD: thr_q      <= pwdata[THR_W-1:0];
				REG_MUTE:      mute_cfg_q <= pwdata[CNT_W-1:0];
				REG_RECOVERY:  rec_cfg_q  <= pwdata[CNT_W-1:0];
				REG_STEP:      step_q     <= pwdata[GAIN_W-1:0];
				REG_CEIL_EN:   ceil_en_q  <= pwdata[0];
				REG_CEIL_LVL:  ceil_lvl_q <= pwdata[LVL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DC_POLE:   prdata = 32'(pole_q);
			REG_THRESHOLD: prdata = 32'(thr_q);
			REG_MUTE:      prdata = 32'(mute_cfg_q);
			REG_RECOVERY:  prdata = 32'(rec_cfg_q);
			REG_STEP:      prdata = 32'(step_q);
			REG_CEIL_EN:   prdata = 32'(ceil_en_q);
			REG_CEIL_LVL:  prdata = 32'(ceil_lvl_q);
			default:       prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	state_t            state_q;
	logic [STEP_W-1:0] cnt_q;
	logic [1:0]        bad_q;
	logic              in_xfer;
	logic              out_free;
	aop_ctrl_t         ctrl;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid & s_axis_tready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	always_comb begin
		ctrl            = '0;
		ctrl.load_x     = in_xfer;
		ctrl.step       = (state_q == ST_FILT) || (state_q == ST_GAIN);
		ctrl.gain_phase = (state_q == ST_GAIN);
		ctrl.filt_done  = (state_q == ST_EVAL);
		ctrl.load_gain  = (state_q == ST_EVAL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_FILT;
						cnt_q   <= STEP_W'(POLE_W - 1);
					end
				end
				ST_FILT: begin
					if (cnt_q == '0) begin
						state_q <= ST_EVAL;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_EVAL: begin
					state_q <= ST_GAIN;
					cnt_q   <= STEP_W'(GAIN_W - 1);
				end
				ST_GAIN: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			bad_q <= s_axis_tuser;
		end
	end

	// ---------------------------------------------------------------
	// Channel lanes
	// ---------------------------------------------------------------
	mode_t             mode_q;
	logic [GAIN_W-1:0] ramp_q;
	logic [GAIN_W-1:0] gain_sel;
	logic signed [OUT_W-1:0] y_c   [2];
	logic signed [OUT_W-1:0] res_c [2];

	// gain held before the frame; unity outside recovery
	assign gain_sel = (mode_q == MODE_REC) ? ramp_q : UNITY;

	for (genvar c = 0; c < 2; c++) begin : g_lane
		if (c < CHANNELS) begin : g_on
			aop_lane #(
				.SAMPLE_BITS (SAMPLE_BITS)
			) u_lane (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.sample   (s_axis_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
				.invalid  (s_axis_tuser[c]),
				.pole     (pole_q),
				.gain     (gain_sel),
				.ceil_en  (ceil_en_q),
				.ceil_lvl (ceil_lvl_q),
				.filtered (y_c[c]),
				.result   (res_c[c])
			);
		end else begin : g_off
			assign y_c[c]   = '0;
			assign res_c[c] = '0;
		end
	end

	// ---------------------------------------------------------------
	// Trigger check, left before right, invalid before peak
	// ---------------------------------------------------------------
	logic [1:0]       cause;
	logic [OUT_W-1:0] mag [2];

	always_comb begin
		cause = CAUSE_NONE;
		for (int c = 0; c < 2; c++) begin
			mag[c] = y_c[c][OUT_W-1] ? OUT_W'(-y_c[c]) : OUT_W'(y_c[c]);
		end
		for (int c = 0; c < CHANNELS; c++) begin
			if (cause == CAUSE_NONE) begin
				if (bad_q[c]) begin
					cause = CAUSE_INVALID;
				end else if (mag[c] >= OUT_W'(thr_q)) begin
					cause = CAUSE_PEAK;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Mode update for the frame
	// ---------------------------------------------------------------
	mode_t             mode_d;
	logic [CNT_W-1:0]  mute_left_q, mute_left_d;
	logic [CNT_W-1:0]  rec_left_q, rec_left_d;
	logic [GAIN_W-1:0] ramp_d;
	logic [CNT_W-1:0]  rec_dec;
	logic [GAIN_W:0]   g_sum;
	logic [GAIN_W-1:0] g_new;
	logic              silent;

	assign rec_dec = (rec_left_q != '0) ? rec_left_q - 1'b1 : '0;
	assign g_sum   = {1'b0, ramp_q} + {1'b0, step_q};
	assign g_new   = (g_sum > {1'b0, UNITY}) ? UNITY : g_sum[GAIN_W-1:0];
	assign silent  = (cause != CAUSE_NONE) || (mode_q == MODE_MUTED);

	always_comb begin
		mode_d      = mode_q;
		mute_left_d = mute_left_q;
		rec_left_d  = rec_left_q;
		ramp_d      = ramp_q;
		if (cause != CAUSE_NONE) begin
			// enter mute, then count this frame as the first muted one
			rec_left_d = (rec_cfg_q == '0) ? CNT_W'(1) : rec_cfg_q;
			ramp_d     = '0;
			if (mute_cfg_q[CNT_W-1:1] == '0) begin
				mute_left_d = '0;
				mode_d      = MODE_REC;
			end else begin
				mute_left_d = mute_cfg_q - 1'b1;
				mode_d      = MODE_MUTED;
			end
		end else begin
			case (mode_q)
				MODE_MUTED: begin
					if (mute_left_q[CNT_W-1:1] == '0) begin
						mute_left_d = '0;
						mode_d      = MODE_REC;
					end else begin
						mute_left_d = mute_left_q - 1'b1;
					end
				end
				MODE_REC: begin
					if (rec_dec == '0 || g_new >= UNITY) begin
						mode_d     = MODE_NORMAL;
						rec_left_d = '0;
						ramp_d     = UNITY;
					end else begin
						rec_left_d = rec_dec;
						ramp_d     = g_new;
					end
				end
				default: mode_d = MODE_NORMAL;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Mode state and output register
	// ---------------------------------------------------------------
	logic done_fire;

	assign done_fire = (state_q == ST_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_NORMAL;
			mute_left_q   <= '0;
			rec_left_q    <= '0;
			ramp_q        <= UNITY;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (done_fire) begin
				mode_q        <= mode_d;
				mute_left_q   <= mute_left_d;
				rec_left_q    <= rec_left_d;
				ramp_q        <= ramp_d;
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done_fire) begin
			m_axis_tdata[OUT_W-1:0]       <= silent ? '0 : res_c[0];
			m_axis_tdata[2*OUT_W-1:OUT_W] <= silent ? '0 : res_c[1];
			m_axis_tuser[0]               <= (mode_d != MODE_NORMAL);
			m_axis_tuser[2:1]             <= cause;
		end
	end

endmodule

/* bench/protector_checker.sv */
`timescale 1ns / 100ps

// Watches the config port and both streams, keeps its own copy of the DC
// blocker and the mute/recover sequencer, and compares every output frame.
module protector_checker (
	input  logic                                              clk,
	input  logic                                              arst_n,
	input  logic                                              psel,
	input  logic                                              penable,
	input  logic                                              pwrite,
	input  logic                                              pready,
	input  logic [aop_pkg::ADDR_W-1:0]                        paddr,
	input  logic [31:0]                                       pwdata,
	input  logic                                              s_axis_tvalid,
	input  logic                                              s_axis_tready,
	input  logic [((2*aop_pkg::SAMPLE_BITS_DEF+7)/8)*8-1:0]   s_axis_tdata,
	input  logic [1:0]                                        s_axis_tuser,
	input  logic                                              m_axis_tvalid,
	input  logic                                              m_axis_tready,
	input  logic [2*aop_pkg::OUT_W-1:0]                       m_axis_tdata,
	input  logic [2:0]                                        m_axis_tuser,
	output int                                                fail_count,
	output int                                                pending,
	output int                                                frames_checked,
	output int                                                invalid_trips,
	output int                                                peak_trips
);
	import aop_pkg::*;

	typedef enum logic [1:0] {
		MODE_NORMAL,
		MODE_MUTED,
		MODE_RECOVERING
	} prot_mode_t;

	typedef struct packed {
		logic [OUT_W-1:0] left;
		logic [OUT_W-1:0] right;
		logic             active;
		logic [1:0]       cause;
	} frame_out_t;

	localparam longint UNITY_Q24   = longint'(UNITY);
	localparam longint HALF_Q16    = longint'(1) << 15;
	localparam longint HALF_Q24    = longint'(1) << 23;
	localparam longint SAT_HI      = (longint'(1) << (OUT_W - 1)) - 1;
	localparam longint SAT_LO      = -(longint'(1) << (OUT_W - 1));
	localparam int     MAX_REPORTS = 100;

	longint pole_cfg, thresh_cfg, mute_cfg, ramp_len_cfg, ramp_step_cfg;
	longint clamp_en_cfg, clamp_lvl_cfg;

	longint     prev_in [2];
	longint     prev_filt [2];
	prot_mode_t prot_mode;
	longint     mute_cnt, ramp_cnt, ramp_gain;

	frame_out_t expected_frames [$];
	int         err_cnt, reports, n_checked, n_invalid, n_peak;

	function automatic longint clip_q523(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// one frame of the mute countdown / gain ramp
	function automatic void advance_mode();
		case (prot_mode)
			MODE_MUTED: begin
				if (mute_cnt <= 1) begin
					mute_cnt  = 0;
					prot_mode = MODE_RECOVERING;
				end else begin
					mute_cnt--;
				end
			end
			MODE_RECOVERING: begin
				ramp_gain = ramp_gain + ramp_step_cfg;
				if (ramp_gain > UNITY_Q24)
					ramp_gain = UNITY_Q24;
				if (ramp_cnt > 0)
					ramp_cnt--;
				if (ramp_cnt == 0 || ramp_gain >= UNITY_Q24) begin
					prot_mode = MODE_NORMAL;
					ramp_cnt  = 0;
					ramp_gain = UNITY_Q24;
				end
			end
			default: prot_mode = MODE_NORMAL;
		endcase
	endfunction

	function automatic frame_out_t protect_frame(
		input logic [SAMPLE_BITS_DEF-1:0] in_l,
		input logic [SAMPLE_BITS_DEF-1:0] in_r,
		input logic                       bad_l,
		input logic                       bad_r
	);
		logic [SAMPLE_BITS_DEF-1:0] smp [2];
		logic                       bad [2];
		longint                     y [2];
		longint                     x, v, g;
		logic [1:0]                 cause;
		frame_out_t                 res;
		smp[0] = in_l;
		smp[1] = in_r;
		bad[0] = bad_l;
		bad[1] = bad_r;
		res    = '0;
		cause  = CAUSE_NONE;
		// bad samples enter the filter as zero
		for (int c = 0; c < 2; c++) begin
			x = bad[c] ? 0 : longint'($signed(smp[c]));
			y[c] = clip_q523(x - prev_in[c] + ((pole_cfg * prev_filt[c] + HALF_Q16) >>> 16));
			prev_in[c]   = x;
			prev_filt[c] = y[c];
		end
		// left before right, flag before magnitude
		for (int c = 0; c < 2; c++)
			if (cause == CAUSE_NONE) begin
				if (bad[c])
					cause = CAUSE_INVALID;
				else if ((y[c] < 0 ? -y[c] : y[c]) >= thresh_cfg)
					cause = CAUSE_PEAK;
			end
		if (cause != CAUSE_NONE) begin
			prot_mode = MODE_MUTED;
			mute_cnt  = (mute_cfg != 0) ? mute_cfg : 1;
			ramp_cnt  = (ramp_len_cfg != 0) ? ramp_len_cfg : 1;
			ramp_gain = 0;
		end else if (prot_mode != MODE_MUTED) begin
			g = (prot_mode == MODE_RECOVERING) ? ramp_gain : UNITY_Q24;
			for (int c = 0; c < 2; c++) begin
				v = (y[c] * g + HALF_Q24) >>> 24;
				if (clamp_en_cfg != 0) begin
					if (v > clamp_lvl_cfg)
						v = clamp_lvl_cfg;
					if (v < -clamp_lvl_cfg)
						v = -clamp_lvl_cfg;
				end
				v = clip_q523(v);
				if (c == 0)
					res.left = OUT_W'(v);
				else
					res.right = OUT_W'(v);
			end
		end
		advance_mode();
		res.active = (prot_mode != MODE_NORMAL);
		res.cause  = cause;
		return res;
	endfunction

	function automatic void report_field(input string field, input longint want,
		input longint got);
		err_cnt++;
		if (reports < MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		else if (reports == MAX_REPORTS)
			$display("%0t: further mismatch reports suppressed", $time);
		reports++;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		frame_out_t want;
		if (!arst_n) begin
			// register defaults
			pole_cfg      = 65493;
			thresh_cfg    = 8388608;
			mute_cfg      = 48;
			ramp_len_cfg  = 48;
			ramp_step_cfg = 349525;
			clamp_en_cfg  = 0;
			clamp_lvl_cfg = 8378953;
			prev_in       = '{0, 0};
			prev_filt     = '{0, 0};
			prot_mode     = MODE_NORMAL;
			mute_cnt      = 0;
			ramp_cnt      = 0;
			ramp_gain     = UNITY_Q24;
			expected_frames.delete();
		end else begin
			if (psel && penable && pwrite && pready)
				case (paddr[4:2])
					REG_DC_POLE:   pole_cfg      = pwdata[POLE_W-1:0];
					REG_THRESHOLD: thresh_cfg    = pwdata[THR_W-1:0];
					REG_MUTE:      mute_cfg      = pwdata[CNT_W-1:0];
					REG_RECOVERY:  ramp_len_cfg  = pwdata[CNT_W-1:0];
					REG_STEP:      ramp_step_cfg = pwdata[GAIN_W-1:0];
					REG_CEIL_EN:   clamp_en_cfg  = pwdata[0];
					REG_CEIL_LVL:  clamp_lvl_cfg = pwdata[LVL_W-1:0];
					default: ;
				endcase
			if (m_axis_tvalid && m_axis_tready) begin
				n_checked++;
				if (expected_frames.size() == 0) begin
					report_field("unexpected frame, out_left", 0,
						$signed(m_axis_tdata[OUT_W-1:0]));
				end else begin
					want = expected_frames.pop_front();
					if (m_axis_tdata[OUT_W-1:0] !== want.left)
						report_field("out_left", $signed(want.left),
							$signed(m_axis_tdata[OUT_W-1:0]));
					if (m_axis_tdata[2*OUT_W-1:OUT_W] !== want.right)
						report_field("out_right", $signed(want.right),
							$signed(m_axis_tdata[2*OUT_W-1:OUT_W]));
					if (m_axis_tuser[0] !== want.active)
						report_field("protection_active", want.active, m_axis_tuser[0]);
					if (m_axis_tuser[2:1] !== want.cause)
						report_field("trigger_cause", want.cause, m_axis_tuser[2:1]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				want = protect_frame(s_axis_tdata[SAMPLE_BITS_DEF-1:0],
					s_axis_tdata[2*SAMPLE_BITS_DEF-1:SAMPLE_BITS_DEF],
					s_axis_tuser[0], s_axis_tuser[1]);
				if (want.cause == CAUSE_INVALID)
					n_invalid++;
				if (want.cause == CAUSE_PEAK)
					n_peak++;
				expected_frames.push_back(want);
			end
		end
		fail_count     <= err_cnt;
		pending        <= expected_frames.size();
		frames_checked <= n_checked;
		invalid_trips  <= n_invalid;
		peak_trips     <= n_peak;
	end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

// Stimulus and verdict for the output protector. The checker instance does
// all prediction and comparison; this module only drives the ports.
module testbench;
	import aop_pkg::*;

	localparam int S_DATA_W       = ((2*SAMPLE_BITS_DEF + 7) / 8) * 8;
	localparam int WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
	localparam int RX_HOLD_CYCLES = 600;   // long sink back-pressure stretch
	localparam int TAIL_CYCLES    = 60;    // idle wait after the final drain

	logic                  clk;
	logic                  arst_n;
	logic                  psel, penable, pwrite, pready;
	logic [ADDR_W-1:0]     paddr;
	logic [31:0]           pwdata, prdata;
	logic                  s_axis_tvalid, s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;   // sample_left, sample_right
	logic [1:0]            s_axis_tuser;   // invalid_left, invalid_right
	logic                  m_axis_tvalid, m_axis_tready;
	logic [2*OUT_W-1:0]    m_axis_tdata;   // out_left, out_right
	logic [2:0]            m_axis_tuser;   // protection_active, trigger_cause[1:0]

	int fail_count, pending, frames_checked, invalid_trips, peak_trips;

	bit tx_burst;  // source offers back to back while set
	bit rx_burst;  // sink accepts without stalls while set
	bit rx_hold;   // request for one long sink hold-off

	initial clk = 1'b0;
	always #2 clk = ~clk;

	audio_output_protector dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	protector_checker frame_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.s_axis_tuser   (s_axis_tuser),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tuser   (m_axis_tuser),
		.fail_count     (fail_count),
		.pending        (pending),
		.frames_checked (frames_checked),
		.invalid_trips  (invalid_trips),
		.peak_trips     (peak_trips)
	);

	// Setup cycle then access cycle. The leading edge keeps psel from being
	// dropped and raised in the same step when writes follow each other.
	task automatic apb_write(input logic [2:0] index, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Stop offering and wait until every predicted frame has come out.
	// pending is registered in the checker, so a zero seen here is settled.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Registers change only with the pipe empty.
	task automatic load_settings(input logic [31:0] pole, input logic [31:0] thresh,
		input logic [31:0] mute, input logic [31:0] ramp_len, input logic [31:0] step,
		input logic [31:0] clamp_en, input logic [31:0] clamp_lvl);
		drain_results();
		apb_write(REG_DC_POLE, pole);
		apb_write(REG_THRESHOLD, thresh);
		apb_write(REG_MUTE, mute);
		apb_write(REG_RECOVERY, ramp_len);
		apb_write(REG_STEP, step);
		apb_write(REG_CEIL_EN, clamp_en);
		apb_write(REG_CEIL_LVL, clamp_lvl);
	endtask

	// One frame transfer. tvalid stays up after the transfer so a zero gap
	// keeps the stream dense; a nonzero gap lowers it first.
	task automatic send_frame(input logic [SAMPLE_BITS_DEF-1:0] left,
		input logic [SAMPLE_BITS_DEF-1:0] right, input logic bad_l, input logic bad_r);
		int gap;
		if ($urandom_range(0, 49) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {right, left};
		s_axis_tuser  <= {bad_r, bad_l};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Random frames: mostly uniform random samples at a random level,
	// plus a per-mille share of invalid flags and full-scale junk.
	task automatic run_phase(input int ph, input int items, input int noise_permil);
		logic [SAMPLE_BITS_DEF-1:0] left, right;
		logic                       bad_l, bad_r;
		int                         kind, amp;
		for (int i = 0; i < items; i++) begin
			// one long sink hold-off and one mid-run drain
			if (ph == 3 && i == 100)
				rx_hold = 1'b1;
			if (ph == 4 && i == 120)
				drain_results();
			kind  = $urandom_range(0, 999);
			amp   = 1 << $urandom_range(4, 21);
			left  = SAMPLE_BITS_DEF'(int'($urandom_range(0, 2 * amp)) - amp);
			right = SAMPLE_BITS_DEF'(int'($urandom_range(0, 2 * amp)) - amp);
			bad_l = 1'b0;
			bad_r = 1'b0;
			if (kind < noise_permil / 3) begin
				bad_l = $urandom_range(0, 1);
				bad_r = !bad_l || $urandom_range(0, 1);
				left  = SAMPLE_BITS_DEF'($urandom);
				right = SAMPLE_BITS_DEF'($urandom);
			end else if (kind < noise_permil) begin
				left = SAMPLE_BITS_DEF'($urandom);
				if ($urandom_range(0, 1))
					right = SAMPLE_BITS_DEF'($urandom);
			end
			send_frame(left, right, bad_l, bad_r);
		end
	endtask

	// Sink: random per-frame stalls, dense stretches, and one long
	// hold-off on request so the block backs up into s_axis.
	initial begin : sink
		int stall;
		m_axis_tready <= 1'b0;
		rx_burst = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 14);
			if (rx_hold) begin
				stall   = RX_HOLD_CYCLES;
				rx_hold = 1'b0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog: any transfer on either stream or the config port resets it.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no transfer for %0d cycles, %0d frames outstanding", $time,
			WATCHDOG_LIMIT, pending);
		$display("testbench NOT OK");
		$finish;
	end

	initial begin : stimulus
		tx_burst = 1'b0;
		rx_hold  = 1'b0;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: no feedback, so y = x - x1; minimum threshold, one-frame
		// mute, two-frame ramp at quarter-unity steps, no ceiling.
		load_settings(0, 8388608, 1, 2, 4194304, 0, 8378953);
		send_frame(24'h000000, 24'h000000, 1'b0, 1'b0);
		send_frame(24'h3FFFFF, 24'hC00000, 1'b0, 1'b0);
		send_frame(24'h000001, 24'hFFFFFF, 1'b0, 1'b0);
		send_frame(24'h7FFFFF, 24'h000000, 1'b0, 1'b0);  // just under threshold
		send_frame(24'h800000, 24'h000000, 1'b0, 1'b0);  // peak trip on left
		send_frame(24'h000000, 24'h000000, 1'b1, 1'b0);  // invalid left
		send_frame(24'h000000, 24'h000000, 1'b0, 1'b1);  // invalid right
		send_frame(24'h7FFFFF, 24'h800000, 1'b1, 1'b1);  // both invalid, full scale
		repeat (4)
			send_frame(24'h000100, 24'hFFFF00, 1'b0, 1'b0);  // ramp back up
		send_frame(24'h7FFFFF, 24'h7FFFFF, 1'b0, 1'b0);  // peak trip on right

		// zero threshold trips on every frame; zero counts act as one
		load_settings(0, 0, 0, 0, 4194304, 0, 8378953);
		send_frame(24'h000000, 24'h000000, 1'b0, 1'b0);
		send_frame(24'h123456, 24'h654321, 1'b0, 1'b0);

		// zero step: the count alone ends the ramp; zero ceiling mutes output
		load_settings(65535, 134217727, 1, 3, 0, 1, 0);
		send_frame(24'h000000, 24'h000000, 1'b1, 1'b1);
		repeat (4)
			send_frame(24'h400000, 24'hC00000, 1'b0, 1'b0);

		// register defaults, rare trips
		load_settings(65493, 8388608, 48, 48, 349525, 0, 8378953);
		run_phase(0, 260, 15);
		// extremes: no feedback, top threshold, longest mute, finest step,
		// lowest ceiling
		load_settings(0, 134217727, 1048575, 1048575, 1, 1, 1056072);
		run_phase(1, 120, 40);
		// extremes: full feedback, lowest threshold, shortest mute and ramp,
		// unity step, highest ceiling
		load_settings(65535, 8388608, 1, 1, 16777216, 1, 8378953);
		run_phase(2, 220, 80);
		for (int ph = 3; ph < 9; ph++) begin
			load_settings($urandom_range(0, 65535), $urandom_range(8388608, 33554432),
				$urandom_range(1, 16), $urandom_range(1, 32),
				$urandom_range(1, 16777216), $urandom_range(0, 1),
				$urandom_range(1056072, 8378953));
			run_phase(ph, 210, 60);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Checked %0d frames: directed edge cases and nine register settings, %0d invalid",
			frames_checked, invalid_trips);
		$display("and %0d peak trips, random gaps and stalls, one %0d-cycle sink hold-off.",
			peak_trips, RX_HOLD_CYCLES);
		if (fail_count == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
